// ===== design/octave_gradient_noise_2d_core_assert.svh =====
// Assertion macros shared by the octave gradient noise core.
`ifndef OCTAVE_GRADIENT_NOISE_2D_CORE_ASSERT_SVH
`define OCTAVE_GRADIENT_NOISE_2D_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OGN_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("octave noise core: delayed property failed");
`define OGN_ASSERT_PAST(lbl, clk, rst_n, cons, ante, dly) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cons) |-> $past(ante, dly)) \
		else $error("octave noise core: past property failed");
`else
`define OGN_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons)
`define OGN_ASSERT_PAST(lbl, clk, rst_n, cons, ante, dly)
`endif
`endif

// ===== design/ogn_pkg.sv =====
// Shared types, constants and table functions of the octave gradient noise core.
package ogn_pkg;
	localparam int MAX_OCTAVES_DEF = 4;
	localparam int ANGLE_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF = 16;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 56;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OCTAVE_COUNT = 4'd0,
		REG_INV_ZOOM = 4'd1,
		REG_SHIFT_X = 4'd2,
		REG_SHIFT_Y = 4'd3,
		REG_SEEDS_LOW = 4'd4,
		REG_SEEDS_HIGH = 4'd5
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] octave_count;
		logic [31:0] inv_zoom;
		logic [31:0] shift_x;
		logic [31:0] shift_y;
		logic [55:0] seeds_low;
		logic [55:0] seeds_high;
	} cfg_t;

	localparam logic [2:0] OCTAVE_COUNT_RST = 3'd4;
	localparam logic [31:0] INV_ZOOM_RST = 32'd327680;

	localparam logic [31:0] HASH_C1 = 32'd3284157443;
	localparam logic [31:0] HASH_C2 = 32'd1911520717;
	localparam logic [31:0] HASH_C3 = 32'd2048419325;

	localparam logic [63:0] SIN_C0 = 64'd1686629713;
	localparam logic [63:0] SIN_C1 = 64'd693598668;
	localparam logic [63:0] SIN_C2 = 64'd85569306;
	localparam logic [63:0] SIN_C3 = 64'd5026996;
	localparam logic [63:0] SIN_C4 = 64'd172272;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	localparam int DOT_W = 34;
	localparam int NOISE_W = 36;
	localparam int WEIGHT_W = 10;
	localparam int WSUM_W = 12;
	localparam int SUM_W = NOISE_W + WEIGHT_W + 4;
	localparam int NUM_SHIFT = 14;
	localparam int HALF_SHIFT = 29;
	localparam int QUOT_W = 28;
	localparam int RECIP_SHIFT = 42;
	localparam int RECIP_W = 33;

	localparam logic [WEIGHT_W-1:0] WEIGHT [8] = '{
		10'd840, 10'd420, 10'd280, 10'd210, 10'd168, 10'd140, 10'd120, 10'd105
	};
	localparam logic [WSUM_W-1:0] WSUM [8] = '{
		12'd840, 12'd1260, 12'd1540, 12'd1750, 12'd1918, 12'd2058, 12'd2178, 12'd2283
	};
	localparam logic [RECIP_W-1:0] RECIP [8] = '{
		33'((64'd1 << 42) / 64'd840 + 64'd1),
		33'((64'd1 << 42) / 64'd1260 + 64'd1),
		33'((64'd1 << 42) / 64'd1540 + 64'd1),
		33'((64'd1 << 42) / 64'd1750 + 64'd1),
		33'((64'd1 << 42) / 64'd1918 + 64'd1),
		33'((64'd1 << 42) / 64'd2058 + 64'd1),
		33'((64'd1 << 42) / 64'd2178 + 64'd1),
		33'((64'd1 << 42) / 64'd2283 + 64'd1)
	};

	function automatic logic [30:0] quarter_sin(input int unsigned r, input int unsigned abits);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] t;
		logic [63:0] v;
		u = 64'(r) << (32 - abits);
		u2 = (u * u) >> 30;
		t = SIN_C3 - ((u2 * SIN_C4) >> 30);
		t = SIN_C2 - ((u2 * t) >> 30);
		t = SIN_C1 - ((u2 * t) >> 30);
		t = SIN_C0 - ((u2 * t) >> 30);
		v = (u * t) >> 30;
		if (v > ONE_Q30) begin
			v = ONE_Q30;
		end
		return v[30:0];
	endfunction
endpackage

// ===== design/ogn_cfg.sv =====
// Configuration register file of the octave gradient noise core.
module ogn_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ogn_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ogn_pkg::CFG_DATA_W-1:0] cfg_data,
	output ogn_pkg::cfg_t cfg
);
	ogn_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.octave_count <= ogn_pkg::OCTAVE_COUNT_RST;
			cfg_q.inv_zoom <= ogn_pkg::INV_ZOOM_RST;
			cfg_q.shift_x <= '0;
			cfg_q.shift_y <= '0;
			cfg_q.seeds_low <= '0;
			cfg_q.seeds_high <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (ogn_pkg::reg_idx_t'(cfg_index))
				ogn_pkg::REG_OCTAVE_COUNT: cfg_q.octave_count <= cfg_data[2:0];
				ogn_pkg::REG_INV_ZOOM: cfg_q.inv_zoom <= cfg_data[31:0];
				ogn_pkg::REG_SHIFT_X: cfg_q.shift_x <= cfg_data[31:0];
				ogn_pkg::REG_SHIFT_Y: cfg_q.shift_y <= cfg_data[31:0];
				ogn_pkg::REG_SEEDS_LOW: cfg_q.seeds_low <= cfg_data;
				ogn_pkg::REG_SEEDS_HIGH: cfg_q.seeds_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== design/ogn_corner.sv =====
// Corner hash, gradient lookup and dot product pipeline of one cell corner.
module ogn_corner #(
	parameter int ANGLE_BITS = ogn_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS = ogn_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic [31:0] cx,
	input logic [31:0] cy,
	input logic signed [FRAC_BITS:0] dx,
	input logic signed [FRAC_BITS:0] dy,
	output logic signed [ogn_pkg::DOT_W-1:0] dot
);
	localparam int QUARTER = 1 << (ANGLE_BITS - 2);
	localparam int RW = ANGLE_BITS - 1;
	localparam int PW = 32 + FRAC_BITS + 2;

	logic [30:0] qtab [QUARTER+1];

	for (genvar i = 0; i <= QUARTER; i++) begin : g_tab
		assign qtab[i] = ogn_pkg::quarter_sin(i, ANGLE_BITS);
	end

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	function automatic logic signed [31:0] step_sin(input logic [ANGLE_BITS-1:0] idx);
		logic [1:0] q;
		logic [RW-1:0] r;
		logic [31:0] mag;
		q = idx[ANGLE_BITS-1 -: 2];
		r = {1'b0, idx[ANGLE_BITS-3:0]};
		if (q[0]) begin
			r = RW'(QUARTER) - r;
		end
		mag = {1'b0, qtab[r]};
		return q[1] ? -$signed(mag) : $signed(mag);
	endfunction

	logic [31:0] a_s1, cy_s1, a_s2, b_s2, h3;
	logic signed [FRAC_BITS:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3, dx_s4, dy_s4;
	logic [ANGLE_BITS-1:0] idx_s3;
	logic signed [31:0] cos_s4, sin_s4;
	logic signed [PW-1:0] dsum;

	assign h3 = 32'((a_s2 ^ rot16(b_s2)) * ogn_pkg::HASH_C3);
	assign dsum = PW'(cos_s4) * PW'(dx_s4) + PW'(sin_s4) * PW'(dy_s4);

	always_ff @(posedge clk) begin
		a_s1 <= 32'(cx * ogn_pkg::HASH_C1);
		cy_s1 <= cy;
		dx_s1 <= dx;
		dy_s1 <= dy;
		b_s2 <= 32'((cy_s1 ^ rot16(a_s1)) * ogn_pkg::HASH_C2);
		a_s2 <= a_s1;
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		idx_s3 <= h3[31 -: ANGLE_BITS];
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		cos_s4 <= step_sin(idx_s3 + ANGLE_BITS'(QUARTER));
		sin_s4 <= step_sin(idx_s3);
		dx_s4 <= dx_s3;
		dy_s4 <= dy_s3;
		dot <= ogn_pkg::DOT_W'(dsum >>> FRAC_BITS);
	end
endmodule

// ===== design/ogn_lane.sv =====
// Pipeline of one octave: scaling, cell split, corner gradients, smoothstep and lerps.
module ogn_lane #(
	parameter int OCT = 0,
	parameter int ANGLE_BITS = ogn_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS = ogn_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic signed [31:0] x,
	input logic signed [31:0] y,
	input logic [31:0] inv_zoom,
	input logic signed [31:0] shift_x,
	input logic signed [31:0] shift_y,
	input logic [13:0] seed_x,
	input logic [13:0] seed_y,
	output logic signed [ogn_pkg::NOISE_W-1:0] noise
);
	localparam int D = 40 - FRAC_BITS - OCT;
	localparam int EW = FRAC_BITS + 2;
	localparam int NW = ogn_pkg::NOISE_W;
	localparam int LPW = NW + EW + 2;

	function automatic logic signed [NW-1:0] lerp(input logic signed [NW-1:0] a,
			input logic signed [NW-1:0] b, input logic [EW-1:0] e);
		logic signed [LPW-1:0] diff;
		logic signed [LPW-1:0] prod;
		diff = LPW'(b) - LPW'(a);
		prod = diff * LPW'($signed({1'b0, e}));
		return a + NW'(prod >>> FRAC_BITS);
	endfunction

	logic signed [34:0] sx_s1, sy_s1;
	logic signed [67:0] px, py, qx, qy;
	logic [31:0] cx_s2, cy_s2;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2, fx_s3, fy_s3;
	logic [FRAC_BITS-1:0] t2x_s3, t2y_s3, t2x_s4, t2y_s4, t3x_s4, t3y_s4;
	logic [2*FRAC_BITS-1:0] sqx, sqy, cbx, cby;
	logic [EW-1:0] ex_s5, ey_s5, ex_s6, ey_s6, ex_s7, ey_s7, ey_s8;
	logic signed [ogn_pkg::DOT_W-1:0] d0, d1, d2, d3;
	logic signed [NW-1:0] lx0_s8, lx1_s8;

	assign px = sx_s1 * $signed({1'b0, inv_zoom});
	assign py = sy_s1 * $signed({1'b0, inv_zoom});
	assign qx = px >>> D;
	assign qy = py >>> D;
	assign sqx = fx_s2 * fx_s2;
	assign sqy = fy_s2 * fy_s2;
	assign cbx = t2x_s3 * fx_s3;
	assign cby = t2y_s3 * fy_s3;

	always_ff @(posedge clk) begin
		sx_s1 <= 35'(x) + 35'(shift_x) + $signed({5'd0, seed_x, 16'd0});
		sy_s1 <= 35'(y) + 35'(shift_y) + $signed({5'd0, seed_y, 16'd0});
		cx_s2 <= qx[FRAC_BITS+31:FRAC_BITS];
		cy_s2 <= qy[FRAC_BITS+31:FRAC_BITS];
		fx_s2 <= qx[FRAC_BITS-1:0];
		fy_s2 <= qy[FRAC_BITS-1:0];
		t2x_s3 <= sqx[2*FRAC_BITS-1:FRAC_BITS];
		t2y_s3 <= sqy[2*FRAC_BITS-1:FRAC_BITS];
		fx_s3 <= fx_s2;
		fy_s3 <= fy_s2;
		t3x_s4 <= cbx[2*FRAC_BITS-1:FRAC_BITS];
		t3y_s4 <= cby[2*FRAC_BITS-1:FRAC_BITS];
		t2x_s4 <= t2x_s3;
		t2y_s4 <= t2y_s3;
		ex_s5 <= (EW'(t2x_s4) << 1) + EW'(t2x_s4) - (EW'(t3x_s4) << 1);
		ey_s5 <= (EW'(t2y_s4) << 1) + EW'(t2y_s4) - (EW'(t3y_s4) << 1);
		ex_s6 <= ex_s5;
		ey_s6 <= ey_s5;
		ex_s7 <= ex_s6;
		ey_s7 <= ey_s6;
		lx0_s8 <= lerp(NW'(d0), NW'(d1), ex_s7);
		lx1_s8 <= lerp(NW'(d2), NW'(d3), ex_s7);
		ey_s8 <= ey_s7;
		noise <= lerp(lx0_s8, lx1_s8, ey_s8);
	end

	ogn_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c0 (
		.clk(clk), .cx(cx_s2), .cy(cy_s2),
		.dx($signed({1'b0, fx_s2})), .dy($signed({1'b0, fy_s2})), .dot(d0)
	);
	ogn_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c1 (
		.clk(clk), .cx(cx_s2 + 32'd1), .cy(cy_s2),
		.dx($signed({1'b1, fx_s2})), .dy($signed({1'b0, fy_s2})), .dot(d1)
	);
	ogn_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c2 (
		.clk(clk), .cx(cx_s2), .cy(cy_s2 + 32'd1),
		.dx($signed({1'b0, fx_s2})), .dy($signed({1'b1, fy_s2})), .dot(d2)
	);
	ogn_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c3 (
		.clk(clk), .cx(cx_s2 + 32'd1), .cy(cy_s2 + 32'd1),
		.dx($signed({1'b1, fx_s2})), .dy($signed({1'b1, fy_s2})), .dot(d3)
	);
endmodule

// ===== design/ogn_norm.sv =====
// Weighted octave sum, normalization by reciprocal multiply and output saturation.
module ogn_norm #(
	parameter int MAX_OCTAVES = ogn_pkg::MAX_OCTAVES_DEF
) (
	input logic clk,
	input logic [2:0] octave_count,
	input logic signed [ogn_pkg::NOISE_W-1:0] noise [MAX_OCTAVES],
	output logic [15:0] noise_value
);
	localparam int SW = ogn_pkg::SUM_W;
	localparam int NSW = SW - ogn_pkg::NUM_SHIFT;

	logic [2:0] cnt_m1;
	logic signed [SW-1:0] acc;
	logic signed [SW-1:0] num_s1;
	logic [2:0] widx_s1, widx_s2;
	logic [NSW-1:0] nsh;
	logic [ogn_pkg::QUOT_W-1:0] n_s2;
	logic zero_s2, sat_s2, zero_s3, sat_s3;
	logic [ogn_pkg::QUOT_W+ogn_pkg::RECIP_W-1:0] prod_s3;

	always_comb begin
		if (octave_count == 3'd0) begin
			cnt_m1 = 3'd0;
		end else if ({1'b0, octave_count} > 4'(MAX_OCTAVES)) begin
			cnt_m1 = 3'(MAX_OCTAVES - 1);
		end else begin
			cnt_m1 = octave_count - 3'd1;
		end
	end

	always_comb begin
		acc = '0;
		for (int k = 0; k < MAX_OCTAVES; k++) begin
			if (3'(k) <= cnt_m1) begin
				acc = acc + SW'(noise[k]) * SW'($signed({1'b0, ogn_pkg::WEIGHT[k]}));
			end
		end
	end

	assign nsh = NSW'(num_s1 >>> ogn_pkg::NUM_SHIFT);

	always_ff @(posedge clk) begin
		num_s1 <= acc + $signed(SW'({ogn_pkg::WSUM[cnt_m1], {ogn_pkg::HALF_SHIFT{1'b0}}}));
		widx_s1 <= cnt_m1;
		zero_s2 <= num_s1[SW-1] || (num_s1 == '0);
		sat_s2 <= nsh >= NSW'({ogn_pkg::WSUM[widx_s1], 16'd0});
		n_s2 <= nsh[ogn_pkg::QUOT_W-1:0];
		widx_s2 <= widx_s1;
		prod_s3 <= n_s2 * ogn_pkg::RECIP[widx_s2];
		zero_s3 <= zero_s2;
		sat_s3 <= sat_s2;
		if (zero_s3) begin
			noise_value <= 16'd0;
		end else if (sat_s3) begin
			noise_value <= 16'hFFFF;
		end else begin
			noise_value <= prod_s3[ogn_pkg::RECIP_SHIFT +: 16];
		end
	end
endmodule

// ===== design/octave_gradient_noise_2d_core.sv =====
// Top level of the fractal 2D gradient noise core.
//
// A sample point (x_coord, y_coord, signed Q16.16) is taken at each rising edge
// where start is high and busy is low. Busy stays low, so a new point can be
// issued in every cycle and many points are in flight at once.
// Every transaction yields one result: noise_value (unsigned Q0.16) appears on
// the result port for exactly one cycle, marked by done, once the point has
// passed the valid shift register vld_q, and is taken at the edge that samples it.
// Results leave in the order the points came in.
// All octaves run in parallel lanes; the depth is set by the three-multiply
// corner hash, the gradient table and the two lerp steps of each lane, plus
// the four-stage normalization.
// The configuration port takes a register write whenever cfg_valid is high
// (cfg_ready is always high); writes should land only while no point is in
// flight. Reset restores the register defaults and clears all pipeline valid
// bits, so no stale result is ever flagged. The receiver cannot stall the
// core; it must take each result in the cycle that done marks.
`include "octave_gradient_noise_2d_core_assert.svh"
module octave_gradient_noise_2d_core #(
	parameter int MAX_OCTAVES = ogn_pkg::MAX_OCTAVES_DEF,
	parameter int ANGLE_BITS = ogn_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS = ogn_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] x_coord,
	input logic signed [31:0] y_coord,
	output logic [15:0] noise_value,
	output logic done,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ogn_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ogn_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int LAT = 14;

	ogn_pkg::cfg_t cfg;
	logic [LAT-1:0] vld_q;
	logic signed [31:0] x_s0, y_s0;
	logic signed [ogn_pkg::NOISE_W-1:0] lane_noise [MAX_OCTAVES];

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	always_ff @(posedge clk) begin
		x_s0 <= x_coord;
		y_s0 <= y_coord;
	end

	ogn_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
		logic [13:0] seed_x, seed_y;
		if (k < 4) begin : g_seed
			localparam int BASE = (k % 2) * 28;
			logic [55:0] seed_reg;
			assign seed_reg = (k < 2) ? cfg.seeds_low : cfg.seeds_high;
			assign seed_x = seed_reg[BASE +: 14];
			assign seed_y = seed_reg[BASE + 14 +: 14];
		end else begin : g_noseed
			assign seed_x = '0;
			assign seed_y = '0;
		end
		ogn_lane #(.OCT(k), .ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk),
			.x(x_s0),
			.y(y_s0),
			.inv_zoom(cfg.inv_zoom),
			.shift_x($signed(cfg.shift_x)),
			.shift_y($signed(cfg.shift_y)),
			.seed_x(seed_x),
			.seed_y(seed_y),
			.noise(lane_noise[k])
		);
	end

	ogn_norm #(.MAX_OCTAVES(MAX_OCTAVES)) u_norm (
		.clk(clk),
		.octave_count(cfg.octave_count),
		.noise(lane_noise),
		.noise_value(noise_value)
	);

	`OGN_ASSERT_DELAY(a_accept_gives_done, clk, arst_n, start && !busy, 14, done)
	`OGN_ASSERT_PAST(a_done_has_accept, clk, arst_n, done, start && !busy, 14)
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the fractal 2D gradient noise core: directed table plus random phases.
module tb_top;
	localparam int ANGLE_BITS = ogn_pkg::ANGLE_BITS_DEF;
	localparam int FRAC_BITS = ogn_pkg::FRAC_BITS_DEF;
	localparam int LATENCY_WAIT = 24;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int DIRECTED_ROWS = 17;
	localparam logic [ogn_pkg::CFG_IDX_W-1:0] UNUSED_IDX =
		ogn_pkg::CFG_IDX_W'(ogn_pkg::REG_SEEDS_HIGH) + 1'b1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic [15:0] noise_value;
	logic done;
	logic cfg_valid;
	logic cfg_ready;
	logic [ogn_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ogn_pkg::CFG_DATA_W-1:0] cfg_data;

	logic row_has_exp;
	logic [15:0] row_exp;

	logic [2:0] m_octaves;
	logic [31:0] m_zoom;
	logic signed [31:0] m_shift_x;
	logic signed [31:0] m_shift_y;
	logic [55:0] m_seeds_lo;
	logic [55:0] m_seeds_hi;

	logic [15:0] expected_noise [$];
	int mismatches;
	int points_sent;
	int results_seen;
	int idle_cycles;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		bit has_exp;
		logic [15:0] exp_val;
	} point_row_t;

	point_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 16'd32768},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0},
		'{32'h8000_0000, 32'h8000_0000, 1'b0, 16'd0},
		'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd0},
		'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'd0},
		'{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 16'd0},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 16'd0},
		'{32'h0001_0000, 32'h0000_0000, 1'b0, 16'd0},
		'{32'h0000_0000, 32'h0001_0000, 1'b0, 16'd0},
		'{32'h0000_FFFF, 32'h0000_FFFF, 1'b0, 16'd0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'd0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'd0},
		'{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 16'd0},
		'{32'h0080_0000, 32'h0040_8000, 1'b0, 16'd0},
		'{32'hFF00_0000, 32'h00FF_0000, 1'b0, 16'd0},
		'{32'h0000_0001, 32'h0000_0001, 1'b0, 16'd0},
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 16'd32768}
	};

	octave_gradient_noise_2d_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.noise_value(noise_value),
		.done(done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint grad_sin(input logic [31:0] step);
		logic [31:0] quad;
		logic [31:0] r;
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] t;
		longint v;
		step = step & ((32'd1 << ANGLE_BITS) - 1);
		quad = step >> (ANGLE_BITS - 2);
		r = step & ((32'd1 << (ANGLE_BITS - 2)) - 1);
		if (quad[0]) begin
			r = (32'd1 << (ANGLE_BITS - 2)) - r;
		end
		u = 64'(r) << (32 - ANGLE_BITS);
		u2 = (u * u) >> 30;
		t = ogn_pkg::SIN_C3 - ((u2 * ogn_pkg::SIN_C4) >> 30);
		t = ogn_pkg::SIN_C2 - ((u2 * t) >> 30);
		t = ogn_pkg::SIN_C1 - ((u2 * t) >> 30);
		t = ogn_pkg::SIN_C0 - ((u2 * t) >> 30);
		v = longint'((u * t) >> 30);
		if (v > longint'(ogn_pkg::ONE_Q30)) begin
			v = longint'(ogn_pkg::ONE_Q30);
		end
		return quad[1] ? -v : v;
	endfunction

	function automatic longint corner_dot_q30(input logic [31:0] cx, input logic [31:0] cy,
			input longint dx, input longint dy);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] angle;
		a = cx * ogn_pkg::HASH_C1;
		b = cy ^ {a[15:0], a[31:16]};
		b = b * ogn_pkg::HASH_C2;
		a = a ^ {b[15:0], b[31:16]};
		a = a * ogn_pkg::HASH_C3;
		angle = a >> (32 - ANGLE_BITS);
		return (grad_sin(angle + (32'd1 << (ANGLE_BITS - 2))) * dx + grad_sin(angle) * dy)
			>>> FRAC_BITS;
	endfunction

	function automatic logic [63:0] scaled_coord(input longint s, input int oct);
		int d;
		logic [63:0] sl;
		longint sh;
		logic [63:0] lo;
		longint mid;
		d = 40 - FRAC_BITS - oct;
		sl = {32'd0, s[31:0]};
		sh = s >>> 32;
		lo = sl * {32'd0, m_zoom};
		mid = sh * longint'({32'd0, m_zoom});
		return (64'(mid) << (32 - d)) + (lo >> d);
	endfunction

	function automatic longint smoothstep_q(input logic [63:0] t);
		logic [63:0] t2;
		logic [63:0] t3;
		t2 = (t * t) >> FRAC_BITS;
		t3 = (t2 * t) >> FRAC_BITS;
		return longint'(3 * t2 - 2 * t3);
	endfunction

	function automatic longint blend_q30(input longint a, input longint b, input longint e);
		return a + ((e * (b - a)) >>> FRAC_BITS);
	endfunction

	function automatic longint octave_sample(input longint x, input longint y, input int oct);
		logic [55:0] seeds;
		int base;
		longint sx;
		longint sy;
		logic [63:0] qx;
		logic [63:0] qy;
		logic [31:0] cx;
		logic [31:0] cy;
		longint fx;
		longint fy;
		longint one;
		longint ex;
		longint ey;
		seeds = (oct < 2) ? m_seeds_lo : m_seeds_hi;
		base = (oct & 1) * 28;
		sx = longint'((seeds >> base) & 56'h3FFF);
		sy = longint'((seeds >> (base + 14)) & 56'h3FFF);
		one = longint'(1) << FRAC_BITS;
		qx = scaled_coord(x + longint'(m_shift_x) + sx * 65536, oct);
		qy = scaled_coord(y + longint'(m_shift_y) + sy * 65536, oct);
		cx = qx[FRAC_BITS+31:FRAC_BITS];
		cy = qy[FRAC_BITS+31:FRAC_BITS];
		fx = longint'(qx & ((64'd1 << FRAC_BITS) - 1));
		fy = longint'(qy & ((64'd1 << FRAC_BITS) - 1));
		ex = smoothstep_q(64'(fx));
		ey = smoothstep_q(64'(fy));
		return blend_q30(
			blend_q30(corner_dot_q30(cx, cy, fx, fy),
				corner_dot_q30(cx + 1, cy, fx - one, fy), ex),
			blend_q30(corner_dot_q30(cx, cy + 1, fx, fy - one),
				corner_dot_q30(cx + 1, cy + 1, fx - one, fy - one), ex),
			ey);
	endfunction

	function automatic logic [15:0] noise_predict(input logic signed [31:0] x,
			input logic signed [31:0] y);
		int count;
		longint acc;
		longint wsum;
		longint w;
		longint num;
		longint q;
		count = int'(m_octaves);
		if (count < 1) begin
			count = 1;
		end
		if (count > ogn_pkg::MAX_OCTAVES_DEF) begin
			count = ogn_pkg::MAX_OCTAVES_DEF;
		end
		acc = 0;
		wsum = 0;
		for (int k = 1; k <= count; k++) begin
			w = 840 / k;
			acc += octave_sample(longint'(x), longint'(y), k - 1) * w;
			wsum += w;
		end
		num = acc + wsum * (longint'(1) << 29);
		if (num <= 0) begin
			q = 0;
		end else begin
			q = num / (wsum << 14);
			if (q > 65535) begin
				q = 65535;
			end
		end
		return q[15:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (expected_noise.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: result %0h arrived with no transaction pending",
							noise_value);
					end
				end else if (noise_value !== expected_noise[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: noise_value expected %0d got %0d",
							expected_noise[0], noise_value);
					end
					void'(expected_noise.pop_front());
				end else begin
					void'(expected_noise.pop_front());
				end
			end
			if (start && !busy) begin
				points_sent++;
				expected_noise.insert(expected_noise.size(),
					row_has_exp ? row_exp : noise_predict(x_coord, y_coord));
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	task automatic send_point(input logic [31:0] x, input logic [31:0] y, input bit has_exp,
			input logic [15:0] exp_val);
		@(negedge clk);
		start = 1'b1;
		x_coord = x;
		y_coord = y;
		row_has_exp = has_exp;
		row_exp = exp_val;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		wait (expected_noise.size() == 0);
		repeat (LATENCY_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ogn_pkg::CFG_IDX_W-1:0] idx,
			input logic [ogn_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			ogn_pkg::REG_OCTAVE_COUNT: m_octaves = data[2:0];
			ogn_pkg::REG_INV_ZOOM: m_zoom = data[31:0];
			ogn_pkg::REG_SHIFT_X: m_shift_x = data[31:0];
			ogn_pkg::REG_SHIFT_Y: m_shift_y = data[31:0];
			ogn_pkg::REG_SEEDS_LOW: m_seeds_lo = data[55:0];
			ogn_pkg::REG_SEEDS_HIGH: m_seeds_hi = data[55:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [55:0] seed_pack(input bit full);
		logic [55:0] v;
		for (int i = 0; i < 4; i++) begin
			v[i*14 +: 14] = full ? 14'($urandom) : 14'($urandom_range(0, 10000));
		end
		return v;
	endfunction

	function automatic logic [31:0] random_coord(input int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 32'h00FF_FFFF);
			2: return $urandom_range(0, 1) ? 32'h7FFF_0000 + $urandom_range(0, 32'hFFFF)
				: 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
			default: return -$urandom_range(0, 32'h0010_0000);
		endcase
	endfunction

	task automatic config_phase(input int phase);
		logic [2:0] counts [8] = '{3'd0, 3'd1, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd4};
		logic [31:0] zoom;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [55:0] slo;
		logic [55:0] shi;
		zoom = $urandom_range(32'h0001_0000, 32'h0100_0000);
		sx = $urandom_range(0, 32'h0100_0000);
		sy = $urandom_range(0, 32'h0100_0000);
		slo = seed_pack(1'b0);
		shi = seed_pack(1'b0);
		case (phase)
			0: begin
				zoom = 32'd0;
			end
			1: begin
				zoom = 32'hFFFF_FFFF;
				sx = 32'h8000_0000;
				sy = 32'h7FFF_FFFF;
			end
			2: begin
				sx = 32'h7FFF_FFFF;
				sy = 32'h8000_0000;
				slo = {56{1'b1}};
				shi = {56{1'b1}};
			end
			3: begin
				slo = {4{14'd10000}};
				shi = {4{14'd10000}};
			end
			4: begin
				zoom = $urandom;
				sx = $urandom;
				sy = $urandom;
				slo = seed_pack(1'b1);
				shi = seed_pack(1'b1);
			end
			default: ;
		endcase
		write_reg(ogn_pkg::REG_OCTAVE_COUNT,
			ogn_pkg::CFG_DATA_W'({$urandom, $urandom} & ~56'h7 | counts[phase]));
		write_reg(ogn_pkg::REG_INV_ZOOM, ogn_pkg::CFG_DATA_W'(zoom));
		write_reg(ogn_pkg::REG_SHIFT_X, ogn_pkg::CFG_DATA_W'(sx));
		write_reg(ogn_pkg::REG_SHIFT_Y, ogn_pkg::CFG_DATA_W'(sy));
		write_reg(ogn_pkg::REG_SEEDS_LOW, ogn_pkg::CFG_DATA_W'(slo));
		write_reg(ogn_pkg::REG_SEEDS_HIGH, ogn_pkg::CFG_DATA_W'(shi));
		if (phase == 5) begin
			write_reg(UNUSED_IDX, ogn_pkg::CFG_DATA_W'({$urandom, $urandom}));
			write_reg(ogn_pkg::CFG_IDX_W'(15), ogn_pkg::CFG_DATA_W'({$urandom, $urandom}));
		end
	endtask

	initial begin
		int burst;
		int sent;
		arst_n = 1'b0;
		start = 1'b0;
		x_coord = '0;
		y_coord = '0;
		row_has_exp = 1'b0;
		row_exp = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_octaves = ogn_pkg::OCTAVE_COUNT_RST;
		m_zoom = ogn_pkg::INV_ZOOM_RST;
		m_shift_x = '0;
		m_shift_y = '0;
		m_seeds_lo = '0;
		m_seeds_hi = '0;
		mismatches = 0;
		points_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].has_exp,
				directed_rows[i].exp_val);
		end
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			config_phase(phase);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 40);
				for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
					send_point(random_coord($urandom_range(0, 3)),
						random_coord($urandom_range(0, 3)), 1'b0, 16'd0);
					sent++;
				end
				if (phase % 3 != 2) begin
					pause_sender($urandom_range(0, 18));
				end
			end
			wait_drained();
		end

		if (expected_noise.size() != 0) begin
			mismatches++;
		end
		$display("Covered %0d sample points and %0d results over %0d register settings.",
			points_sent, results_seen, PHASES + 1);
		$display("Settings included octave counts zero through seven, zero and full scale, ",
			"extreme shifts and saturated seeds.");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
